// ===== sv/rkc_pkg.sv =====
// ----------------------------------------------------------------------------
// rkc_pkg: shared types and constants of the rolling k-mer code block
// Field widths, register indexes, the control state and the cell link types.
// ----------------------------------------------------------------------------
`default_nettype none

package rkc_pkg;

  localparam int MAX_KMER_DEF  = 32;
  localparam int CODE_BITS_DEF = 64;

  localparam int SYM_W      = 8;
  localparam int Q_W        = 8;
  localparam int K_W        = 6;
  localparam int OFF_W      = 5;
  localparam int POS_W      = 32;
  localparam int CODE_W     = 64;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 104;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [SYM_W-1:0] FIRST_SPECIAL  = 8'd254;
  localparam logic [SYM_W-1:0] WILDCARD_SYM   = 8'd254;
  localparam logic [Q_W-1:0]   ALPHABET_RESET = 8'd4;
  localparam logic [K_W-1:0]   KMER_RESET     = 6'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHABET_SIZE = 8'd0,
    REG_KMER_LENGTH   = 8'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_REPLAY
  } state_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic             step;
    logic             hist_shift;
    logic [SYM_W-1:0] sym;
    logic [Q_W-1:0]   q;
  } cell_ctrl_t;

  // Special-symbol status of a partial window.
  typedef struct packed {
    logic             seen;
    logic [OFF_W-1:0] off;
  } cell_flag_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  start;
    logic              has_special;
    logic [OFF_W-1:0]  off;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/rkc_cell.sv =====
// ----------------------------------------------------------------------------
// rkc_cell: one cell of the k-mer code chain
// Extends the partial window code of its left neighbor by one symbol (one
// multiply-add) and holds one symbol of the history line.
// ----------------------------------------------------------------------------
`default_nettype none

module rkc_cell #(
  parameter int CODE_BITS = rkc_pkg::CODE_BITS_DEF,
  parameter int IDX       = 0
) (
  input  logic                        clk,
  input  rkc_pkg::cell_ctrl_t         ctrl,
  input  logic [CODE_BITS-1:0]        prev_code,
  input  rkc_pkg::cell_flag_t         prev_flag,
  input  logic [rkc_pkg::SYM_W-1:0]   prev_sym,
  output logic [CODE_BITS-1:0]        code,
  output rkc_pkg::cell_flag_t         flag,
  output logic [CODE_BITS-1:0]        code_next,
  output rkc_pkg::cell_flag_t         flag_next,
  output logic [rkc_pkg::SYM_W-1:0]   sym
);
  import rkc_pkg::*;

  logic                   is_special;
  logic                   use_fill;
  logic [CODE_BITS-1:0]   q_ext;
  logic [CODE_BITS-1:0]   eff_sym;
  logic [CODE_BITS+Q_W-1:0] product;

  assign is_special = (ctrl.sym >= FIRST_SPECIAL);
  // From the first special symbol on, every position counts as q-1.
  assign use_fill   = is_special || prev_flag.seen;
  assign q_ext      = {{(CODE_BITS-Q_W){1'b0}}, ctrl.q};
  assign eff_sym    = use_fill ? (q_ext - CODE_BITS'(1))
                               : {{(CODE_BITS-SYM_W){1'b0}}, ctrl.sym};
  assign product    = prev_code * ctrl.q;
  assign code_next  = product[CODE_BITS-1:0] + eff_sym;

  always_comb begin
    flag_next.seen = use_fill;
    if (prev_flag.seen) begin
      flag_next.off = prev_flag.off;
    end else if (is_special) begin
      flag_next.off = OFF_W'(IDX);
    end else begin
      flag_next.off = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      code <= code_next;
      flag <= flag_next;
    end
    if (ctrl.hist_shift) begin
      sym <= prev_sym;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rkc_out_buf.sv =====
// ----------------------------------------------------------------------------
// rkc_out_buf: two-entry result buffer
// Parts the chain from the output stream so a result can wait while the next
// symbol is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rkc_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rkc_pkg::result_t  push_data,
  output logic              space,
  output logic              pop_valid,
  input  logic              pop_ready,
  output rkc_pkg::result_t  pop_data
);
  import rkc_pkg::*;

  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       do_push;
  logic       do_pop;
  result_t    slots [2];

  assign space     = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && space;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rolling_kmer_code_with_wildcards.sv =====
// ----------------------------------------------------------------------------
// rolling_kmer_code_with_wildcards: sliding-window k-mer integer code
// One multiply-add per cell sets the rate; results wait in the output buffer.
// Throughput: one symbol per cycle while in ST_RUN with output buffer space.
// End of sequence: k wildcard symbols are flushed through the chain.
// An alphabet_size write replays the filled window (k symbols at most).
// Reset: synchronous; registers to 4 and 12, window and position cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_kmer_code_with_wildcards #(
  parameter int MAX_KMER  = rkc_pkg::MAX_KMER_DEF,
  parameter int CODE_BITS = rkc_pkg::CODE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: symbol[7:0]; s_tlast: end_of_sequence
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rkc_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                               s_tlast,
  // m_tdata: kmer_code[63:0], start_position[95:64], has_special[96],
  //          special_offset[101:97], zero fill[103:102]; m_tlast: last
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rkc_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rkc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rkc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rkc_pkg::*;

  localparam int KW = $clog2(MAX_KMER + 1);
  localparam int IW = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;

  logic [Q_W-1:0]   alphabet_size;
  logic [K_W-1:0]   kmer_length;
  state_t           state;
  state_t           state_next;
  logic [KW-1:0]    fill;
  logic [POS_W-1:0] pos;
  logic [IW-1:0]    flush_cnt;
  logic [IW-1:0]    replay_idx;

  logic [KW-1:0]    k_eff;
  logic [IW-1:0]    tap;
  logic             in_go;
  logic             flush_go;
  logic             replay_go;
  logic             cfg_go;
  logic             emit;
  logic             buf_space;
  cell_ctrl_t       cell_ctrl;
  result_t          res;
  result_t          out_res;

  logic [CODE_BITS-1:0] code_arr      [MAX_KMER];
  logic [CODE_BITS-1:0] code_next_arr [MAX_KMER];
  logic [CODE_BITS-1:0] prev_code     [MAX_KMER];
  cell_flag_t           flag_arr      [MAX_KMER];
  cell_flag_t           flag_next_arr [MAX_KMER];
  cell_flag_t           prev_flag     [MAX_KMER];
  logic [SYM_W-1:0]     sym_arr       [MAX_KMER];
  logic [SYM_W-1:0]     prev_sym      [MAX_KMER];

  // Window length: zero counts as one, saturate at the chain length.
  always_comb begin
    if (kmer_length == '0) begin
      k_eff = KW'(1);
    end else if (int'(kmer_length) > MAX_KMER) begin
      k_eff = KW'(MAX_KMER);
    end else begin
      k_eff = KW'(kmer_length);
    end
  end

  assign tap = IW'(k_eff - KW'(1));

  assign s_tready = (state == ST_RUN) && buf_space;
  assign cfg_ready = (state == ST_RUN);
  assign cfg_go = cfg_valid && cfg_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (in_go && s_tlast) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (flush_go && flush_cnt == '0) state_next = ST_RUN;
      end
      ST_REPLAY: begin
        if (replay_idx == '0) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
    if (cfg_go) begin
      if (cfg_index == REG_KMER_LENGTH) begin
        state_next = ST_RUN;
      end else if (cfg_index == REG_ALPHABET_SIZE && fill != '0) begin
        state_next = ST_REPLAY;
      end
    end
  end

  // Chain control and result assembly.
  always_comb begin
    in_go     = 1'b0;
    flush_go  = 1'b0;
    replay_go = 1'b0;
    cell_ctrl.sym = s_tdata[SYM_W-1:0];
    unique case (state)
      ST_RUN: begin
        in_go = s_tvalid && s_tready;
      end
      ST_FLUSH: begin
        flush_go = buf_space;
        cell_ctrl.sym = WILDCARD_SYM;
      end
      ST_REPLAY: begin
        replay_go = 1'b1;
        cell_ctrl.sym = sym_arr[replay_idx];
      end
      default: ;
    endcase
    cell_ctrl.step       = in_go || flush_go || replay_go;
    cell_ctrl.hist_shift = in_go || flush_go;
    cell_ctrl.q          = alphabet_size;

    emit = (in_go || flush_go) && (int'(fill) + 1 >= int'(k_eff));
    res.code        = CODE_W'(code_next_arr[tap]);
    res.start       = pos + POS_W'(1) - POS_W'(k_eff);
    res.has_special = flag_next_arr[tap].seen;
    res.off         = flag_next_arr[tap].off;
    res.last        = flush_go ? (flush_cnt == '0) : !s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= ALPHABET_RESET;
      kmer_length   <= KMER_RESET;
      state         <= ST_RUN;
      fill          <= '0;
      pos           <= '0;
      flush_cnt     <= '0;
      replay_idx    <= '0;
    end else begin
      state <= state_next;
      // Flush done: drop the window and restart the position count.
      if (flush_go && flush_cnt == '0) begin
        pos <= '0;
      end else if (in_go || flush_go) begin
        pos <= pos + POS_W'(1);
      end
      if ((cfg_go && cfg_index == REG_KMER_LENGTH) || (flush_go && flush_cnt == '0)) begin
        fill <= '0;
      end else if ((in_go || flush_go) && int'(fill) < int'(k_eff)) begin
        fill <= fill + KW'(1);
      end
      if (in_go && s_tlast) begin
        flush_cnt <= IW'(k_eff - KW'(1));
      end else if (flush_go) begin
        flush_cnt <= flush_cnt - IW'(1);
      end
      if (replay_go) begin
        replay_idx <= replay_idx - IW'(1);
      end
      if (cfg_go) begin
        unique case (cfg_index)
          REG_ALPHABET_SIZE: begin
            alphabet_size <= cfg_data[Q_W-1:0];
            replay_idx    <= IW'(fill - KW'(1));
          end
          REG_KMER_LENGTH: begin
            kmer_length <= cfg_data[K_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  for (genvar i = 0; i < MAX_KMER; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_code[i] = '0;
      assign prev_flag[i] = '0;
      assign prev_sym[i]  = cell_ctrl.sym;
    end else begin : g_link
      assign prev_code[i] = code_arr[i-1];
      assign prev_flag[i] = flag_arr[i-1];
      assign prev_sym[i]  = sym_arr[i-1];
    end

    rkc_cell #(
      .CODE_BITS (CODE_BITS),
      .IDX       (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .prev_code (prev_code[i]),
      .prev_flag (prev_flag[i]),
      .prev_sym  (prev_sym[i]),
      .code      (code_arr[i]),
      .flag      (flag_arr[i]),
      .code_next (code_next_arr[i]),
      .flag_next (flag_next_arr[i]),
      .sym       (sym_arr[i])
    );
  end

  rkc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (res),
    .space     (buf_space),
    .pop_valid (m_tvalid),
    .pop_ready (m_tready),
    .pop_data  (out_res)
  );

  assign m_tdata = {2'b00, out_res.off, out_res.has_special, out_res.start, out_res.code};
  assign m_tlast = out_res.last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= int'(k_eff))
    else $error("window fill exceeds window length");

  a_replay_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPLAY) |-> !emit)
    else $error("result produced during window replay");

  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    (flush_go && flush_cnt == '0) |=> (fill == '0 && pos == '0))
    else $error("stream state not cleared after flush");

  a_flush_entry: assert property (@(posedge clk) disable iff (rst)
    (in_go && s_tlast && !cfg_go) |=> (state == ST_FLUSH))
    else $error("end of sequence did not start the flush");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: rolling k-mer code with wildcard fill
// Streams symbol sequences into the block under random source gaps and sink
// stalls. A local model of the sliding window predicts the code, start
// position and first-special offset of every window, and each result is
// compared as it leaves. Alphabet and window sizes change between sequences,
// out-of-range values and mid-stream alphabet changes included.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rkc_pkg::*;

  localparam int WINDOW_SLOTS   = MAX_KMER_DEF;
  localparam int RANDOM_SYMBOLS = 156;
  // Covers an end-of-sequence flush or an alphabet replay with margin.
  localparam int SETTLE_CYCLES  = 2 * MAX_KMER_DEF + 8;
  // Longest quiet stretch in a correct run is a sink stall plus a settle
  // pause plus a replay, well under the limit below.
  localparam int STUCK_LIMIT    = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'hA5;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  start;
    logic              has_special;
    logic [OFF_W-1:0]  off;
    logic              last;
  } kmer_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_SYMBOL,
    ROW_CHECKED
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           value;  // register data or symbol
    logic                 eos;
    kmer_t                result;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Window model
  logic [Q_W-1:0]    alpha_q;
  logic [K_W-1:0]    kmer_k;
  logic [SYM_W-1:0]  window [WINDOW_SLOTS];
  int unsigned       window_fill;
  int unsigned       oldest_slot;
  logic [POS_W-1:0]  next_position;
  logic [CODE_W-1:0] fill_code [WINDOW_SLOTS];

  kmer_t       expected_kmers [$];
  row_t        stimulus_rows [$];
  kmer_t       seen_kmer;
  kmer_t       due_kmer;
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned run_left = 0;
  bit          quiet = 1'b0;

  rolling_kmer_code_with_wildcards dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned window_len();
    int unsigned k;
    k = 32'(kmer_k);
    if (k == 0) k = 1;
    if (k > WINDOW_SLOTS) k = WINDOW_SLOTS;
    return k;
  endfunction

  // fill_code[f] = q^(k-f) - 1, wrapping at the code width
  function automatic void rebuild_fill();
    logic [CODE_W-1:0] q_wide;
    logic [CODE_W-1:0] power;
    int f;
    q_wide = CODE_W'(alpha_q);
    power = q_wide;
    for (f = 0; f < WINDOW_SLOTS; f++) fill_code[f] = '0;
    for (f = window_len(); f > 0; f--) begin
      fill_code[f-1] = power - CODE_W'(1);
      power = power * q_wide;
    end
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    if (idx == REG_ALPHABET_SIZE) begin
      alpha_q = value;
      rebuild_fill();
    end else if (idx == REG_KMER_LENGTH) begin
      kmer_k = value[K_W-1:0];
      window_fill = 0;
      oldest_slot = 0;
      rebuild_fill();
    end
  endfunction

  function automatic void reset_window_model();
    alpha_q = ALPHABET_RESET;
    kmer_k = KMER_RESET;
    window_fill = 0;
    oldest_slot = 0;
    next_position = '0;
    rebuild_fill();
  endfunction

  // Push one symbol into the window; yield a code once the window is full.
  function automatic bit shift_symbol(input logic [SYM_W-1:0] sym,
                                      input logic [POS_W-1:0] at, output kmer_t r);
    int unsigned k;
    int unsigned i;
    int unsigned f;
    logic [CODE_W-1:0] h;
    logic [CODE_W-1:0] q_wide;
    logic [SYM_W-1:0] s;
    bit special;
    k = window_len();
    q_wide = CODE_W'(alpha_q);
    h = '0;
    f = 0;
    special = 1'b0;
    r = '0;
    if (window_fill < k) begin
      window[window_fill % WINDOW_SLOTS] = sym;
      window_fill++;
    end else begin
      window[oldest_slot % WINDOW_SLOTS] = sym;
      oldest_slot = (oldest_slot + 1) % k;
    end
    if (window_fill < k) return 1'b0;
    for (i = 0; i < k && !special; i++) begin
      s = window[((oldest_slot + i) % k) % WINDOW_SLOTS];
      if (s >= FIRST_SPECIAL) begin
        special = 1'b1;
        f = i;
      end else begin
        h = h * q_wide + CODE_W'(s);
      end
    end
    // positions from the first special on count as q-1
    if (special) h = h * (fill_code[f] + CODE_W'(1)) + fill_code[f];
    r.code = h;
    r.start = at + 1 - k;
    r.has_special = special;
    r.off = f[OFF_W-1:0];
    return 1'b1;
  endfunction

  // Queue every code one request causes; a typed row replaces the single one.
  function automatic int predict_request(input logic [SYM_W-1:0] sym, input logic eos,
                                         input bit use_typed, input kmer_t typed);
    kmer_t batch [WINDOW_SLOTS + 1];
    kmer_t r;
    int n;
    int unsigned o;
    int unsigned k;
    n = 0;
    if (shift_symbol(sym, next_position, r)) begin
      batch[n] = r;
      n++;
    end
    next_position++;
    if (eos) begin
      k = window_len();
      for (o = 0; o < k; o++) begin
        if (shift_symbol(WILDCARD_SYM, next_position + o, r)) begin
          batch[n] = r;
          n++;
        end
      end
      window_fill = 0;
      oldest_slot = 0;
      next_position = '0;
    end
    if (n > 0) batch[n-1].last = 1'b1;
    if (use_typed && n == 1) batch[0] = typed;
    for (o = 0; o < n; o++) expected_kmers.push_back(batch[o]);
    return n;
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.index = idx;
    r.value = value;
    stimulus_rows.push_back(r);
  endfunction

  function automatic void add_symbol(input logic [7:0] sym, input logic eos);
    row_t r;
    r = '0;
    r.kind = ROW_SYMBOL;
    r.value = sym;
    r.eos = eos;
    stimulus_rows.push_back(r);
  endfunction

  function automatic void add_checked(input logic [7:0] sym, input logic [CODE_W-1:0] code,
                                      input logic [POS_W-1:0] start, input logic has_special,
                                      input logic [OFF_W-1:0] off);
    row_t r;
    r = '0;
    r.kind = ROW_CHECKED;
    r.value = sym;
    r.result.code = code;
    r.result.start = start;
    r.result.has_special = has_special;
    r.result.off = off;
    r.result.last = 1'b1;
    stimulus_rows.push_back(r);
  endfunction

  // Drop valid and wait until the block has drained.
  task automatic settle_block();
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_kmers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, value);
  endtask

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic eos, input bit gaps,
                             input bit use_typed, input kmer_t typed);
    cfg_valid <= 1'b0;
    if (gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= sym;
    s_tlast <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    void'(predict_request(sym, eos, use_typed, typed));
  endtask

  // Result checking, stuck counter and sink stalls
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_kmer.code = m_tdata[63:0];
        seen_kmer.start = m_tdata[95:64];
        seen_kmer.has_special = m_tdata[96];
        seen_kmer.off = m_tdata[101:97];
        seen_kmer.last = m_tlast;
        if (expected_kmers.size() == 0) begin
          $error("result with none expected: kmer_code %h start_position %0d",
                 seen_kmer.code, seen_kmer.start);
          mismatch_count++;
        end else begin
          due_kmer = expected_kmers.pop_front();
          if (seen_kmer.code !== due_kmer.code) begin
            $error("kmer_code: expected %h, actual %h", due_kmer.code, seen_kmer.code);
            mismatch_count++;
          end
          if (seen_kmer.start !== due_kmer.start) begin
            $error("start_position: expected %0d, actual %0d", due_kmer.start,
                   seen_kmer.start);
            mismatch_count++;
          end
          if (seen_kmer.has_special !== due_kmer.has_special) begin
            $error("has_special: expected %b, actual %b", due_kmer.has_special,
                   seen_kmer.has_special);
            mismatch_count++;
          end
          if (seen_kmer.off !== due_kmer.off) begin
            $error("special_offset: expected %0d, actual %0d", due_kmer.off, seen_kmer.off);
            mismatch_count++;
          end
          if (seen_kmer.last !== due_kmer.last) begin
            $error("last: expected %b, actual %b", due_kmer.last, seen_kmer.last);
            mismatch_count++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (run_left > 0)
        run_left--;
      else if (!quiet && $urandom_range(0, 2) == 0)
        stall_left = $urandom_range(1, 18);
      else
        run_left = $urandom_range(1, 40);
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int unsigned i;
    int unsigned sent;
    int unsigned seq_len;
    int unsigned k;
    logic [7:0] value;
    logic [SYM_W-1:0] sym;
    bit gaps;
    bit eos_end;
    row_t row;
    kmer_t no_result;
    no_result = '0;
    reset_window_model();

    // Reset sizes: eleven zeros then 3 fill the 12-symbol window
    for (i = 0; i < 11; i++) add_symbol(8'd0, 1'b0);
    add_checked(8'd3, 64'd3, 32'd0, 1'b0, 5'd0);
    add_symbol(8'd255, 1'b1);
    // One-symbol window, largest legal alphabet
    add_write(REG_KMER_LENGTH, 8'd1);
    add_write(REG_ALPHABET_SIZE, 8'd254);
    add_checked(8'd253, 64'd253, 32'd0, 1'b0, 5'd0);
    add_checked(WILDCARD_SYM, 64'd253, 32'd1, 1'b1, 5'd0);
    add_checked(8'd0, 64'd0, 32'd2, 1'b0, 5'd0);
    add_symbol(8'd200, 1'b1);
    // Zero window length acts as one; zero alphabet makes all-ones fill
    add_write(REG_KMER_LENGTH, 8'd0);
    add_write(REG_ALPHABET_SIZE, 8'd0);
    add_write(REG_SPARE, 8'hFF);
    add_checked(8'd5, 64'd5, 32'd0, 1'b0, 5'd0);
    add_checked(WILDCARD_SYM, '1, 32'd1, 1'b1, 5'd0);
    add_symbol(8'd7, 1'b1);
    // Alphabet change with a full window keeps the window
    add_write(REG_KMER_LENGTH, 8'd2);
    add_write(REG_ALPHABET_SIZE, 8'd2);
    add_symbol(8'd1, 1'b0);
    add_checked(8'd1, 64'd3, 32'd0, 1'b0, 5'd0);
    add_write(REG_ALPHABET_SIZE, 8'd3);
    add_checked(8'd2, 64'd5, 32'd1, 1'b0, 5'd0);
    add_symbol(8'd0, 1'b1);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < stimulus_rows.size(); i++) begin
      row = stimulus_rows[i];
      if (row.kind == ROW_WRITE)
        write_register(row.index, row.value);
      else
        send_symbol(row.value, row.eos, 1'b1, row.kind == ROW_CHECKED, row.result);
    end

    sent = 0;
    while (sent < RANDOM_SYMBOLS) begin
      quiet = sent >= RANDOM_SYMBOLS * 4 / 5;
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 7))
          0: value = 8'd2;
          1: value = 8'd254;
          2: value = 8'd0;
          3: value = 8'd1;
          4: value = 8'd255;
          default: value = 8'($urandom_range(2, 16));
        endcase
        write_register(REG_ALPHABET_SIZE, value);
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: value = 8'd0;
          1: value = 8'd32;
          2: value = 8'hFF;
          3: value = 8'($urandom_range(0, 255));
          default: value = 8'($urandom_range(1, 6));
        endcase
        write_register(REG_KMER_LENGTH, value);
      end
      if ($urandom_range(0, 11) == 0)
        write_register(CFG_IDX_W'($urandom_range(2, 255)),
                       CFG_DATA_W'($urandom_range(0, 255)));

      // Mostly sequences long enough to fill the window
      k = window_len();
      if ($urandom_range(0, 4) != 0)
        seq_len = k + $urandom_range(0, 8);
      else
        seq_len = $urandom_range(1, k);
      eos_end = $urandom_range(0, 4) != 0;
      gaps = !quiet && $urandom_range(0, 3) != 0;
      for (i = 0; i < seq_len; i++) begin
        case ($urandom_range(0, 15))
          0: sym = WILDCARD_SYM;
          1: sym = 8'd255;
          2, 3: sym = SYM_W'($urandom_range(0, 255));
          default: begin
            if (alpha_q == 0 || alpha_q > FIRST_SPECIAL)
              sym = SYM_W'($urandom_range(0, FIRST_SPECIAL - 1));
            else
              sym = SYM_W'($urandom_range(0, alpha_q - 1));
          end
        endcase
        send_symbol(sym, eos_end && i == seq_len - 1, gaps, 1'b0, no_result);
        sent++;
      end
    end

    quiet = 1'b1;
    settle_block();
    if (mismatch_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
